// File: design/lpc_pkg.sv
// Shared types and constants for the lidar polar-to-cartesian filter.
package lpc_pkg;

   localparam int BEAM_W     = 10;
   localparam int RANGE_W    = 16;
   localparam int COEF_W     = 16;
   localparam int POS_W      = 16;
   localparam int MARGIN_W   = 10;
   localparam int FIELD_W    = 15;
   localparam int RING_W     = 32;
   localparam int POINT_W    = 18;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam int POINT_MAX = 131071;
   localparam int POINT_MIN = -131072;

   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SENSOR_POS_X = 3'd0,
      CSR_SENSOR_POS_Y = 3'd1,
      CSR_MAX_RANGE    = 3'd2,
      CSR_EDGE_MARGIN  = 3'd3,
      CSR_FIELD_SIZE_X = 3'd4,
      CSR_FIELD_SIZE_Y = 3'd5,
      CSR_RING_MIN_SQ  = 3'd6,
      CSR_RING_MAX_SQ  = 3'd7
   } csr_index_type;

   localparam logic signed [POS_W-1:0] RST_SENSOR_POS_X = 16'sd0;
   localparam logic signed [POS_W-1:0] RST_SENSOR_POS_Y = 16'sd0;
   localparam logic [RANGE_W-1:0]      RST_MAX_RANGE    = 16'd4000;
   localparam logic [MARGIN_W-1:0]     RST_EDGE_MARGIN  = 10'd0;
   localparam logic [FIELD_W-1:0]      RST_FIELD_SIZE_X = 15'd3000;
   localparam logic [FIELD_W-1:0]      RST_FIELD_SIZE_Y = 15'd2000;
   localparam logic [RING_W-1:0]       RST_RING_MIN_SQ  = 32'd0;
   localparam logic [RING_W-1:0]       RST_RING_MAX_SQ  = 32'hFFFF_FFFF;

   // per-request control that rides along the pipeline
   typedef struct packed {
      logic              calibrate;
      logic              in_range;
      logic [BEAM_W-1:0] beam_index;
   } sample_ctl_type;

endpackage

// File: design/lidar_polar_to_cartesian_filter_core.sv
// Lidar range filter: polar samples in, field cartesian points out.
//
// Requests arrive on req_* (valid/ready). A load request (operation 0) writes
// the cosine/sine pair of one beam into the table and produces no response.
// A sample request (operation 1) produces exactly one response on rsp_*:
// the point, or 0,0 with point_valid low when it is rejected.
// Registers are written on csr_* (index, data); csr_ready is always high.
// Write them only while no sample is in flight.
// Pipeline: table read, scale multiply, offset and square, check and output.
// Throughput is one request per cycle while the pipeline is not stalled, with
// the single table read port and one multiplier pair in each of stages 2 and 3.
// Each stage holds on a stall and pulls forward into empty slots, so
// req_ready drops only when all four stages are full and rsp_ready is low.
// Reset clears the pipeline and loads register defaults; the table keeps its
// contents and a beam must be loaded before it is sampled.
module lidar_polar_to_cartesian_filter_core import lpc_pkg::*; #(
   parameter int BEAM_COUNT     = 1024,
   parameter int TRIG_FRAC_BITS = 15
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_operation,
   input  logic [BEAM_W-1:0]          req_beam_index,
   input  logic [RANGE_W-1:0]         req_range_mm,
   input  logic                       req_calibrate,
   input  logic signed [COEF_W-1:0]   req_cos_value,
   input  logic signed [COEF_W-1:0]   req_sin_value,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [POINT_W-1:0]  rsp_point_x,
   output logic signed [POINT_W-1:0]  rsp_point_y,
   output logic                       rsp_point_valid,
   output logic [BEAM_W-1:0]          rsp_point_index,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_data
);

   localparam int AW    = $clog2(BEAM_COUNT);
   localparam int EXT_W = (AW > BEAM_W) ? AW : BEAM_W;
   localparam int QW    = 2 * COEF_W - TRIG_FRAC_BITS;
   localparam int XW    = QW + 2;

   // configuration registers
   logic signed [POS_W-1:0] pos_x_ff, pos_y_ff;
   logic [RANGE_W-1:0]      max_range_ff;
   logic [MARGIN_W-1:0]     margin_ff;
   logic [FIELD_W-1:0]      field_x_ff, field_y_ff;
   logic [RING_W-1:0]       ring_min_ff, ring_max_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff     <= RST_SENSOR_POS_X;
         pos_y_ff     <= RST_SENSOR_POS_Y;
         max_range_ff <= RST_MAX_RANGE;
         margin_ff    <= RST_EDGE_MARGIN;
         field_x_ff   <= RST_FIELD_SIZE_X;
         field_y_ff   <= RST_FIELD_SIZE_Y;
         ring_min_ff  <= RST_RING_MIN_SQ;
         ring_max_ff  <= RST_RING_MAX_SQ;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_SENSOR_POS_X: pos_x_ff     <= csr_data[POS_W-1:0];
            CSR_SENSOR_POS_Y: pos_y_ff     <= csr_data[POS_W-1:0];
            CSR_MAX_RANGE:    max_range_ff <= csr_data[RANGE_W-1:0];
            CSR_EDGE_MARGIN:  margin_ff    <= csr_data[MARGIN_W-1:0];
            CSR_FIELD_SIZE_X: field_x_ff   <= csr_data[FIELD_W-1:0];
            CSR_FIELD_SIZE_Y: field_y_ff   <= csr_data[FIELD_W-1:0];
            CSR_RING_MIN_SQ:  ring_min_ff  <= csr_data[RING_W-1:0];
            CSR_RING_MAX_SQ:  ring_max_ff  <= csr_data[RING_W-1:0];
            default: ;
         endcase
      end
   end

   // stage enables: a stage loads when it is empty or its successor moves
   logic en1, en2, en3, en4;
   logic s1_valid_ff, s2_valid, s3_valid;

   assign en4       = !rsp_valid || rsp_ready;
   assign en3       = !s3_valid || en4;
   assign en2       = !s2_valid || en3;
   assign en1       = !s1_valid_ff || en2;
   assign req_ready = en1;

   // stage 1: table access
   logic [EXT_W-1:0]    beam_ext;
   logic [AW-1:0]       beam_addr;
   logic                beam_ok;
   logic                req_take;
   sample_ctl_type      s1_ctl_in, s1_ctl_ff;
   logic [RANGE_W-1:0]  s1_range_ff;
   logic [2*COEF_W-1:0] trig_rd;

   assign beam_ext  = EXT_W'(req_beam_index);
   assign beam_addr = beam_ext[AW-1:0];
   assign beam_ok   = 32'(req_beam_index) < 32'(BEAM_COUNT);
   assign req_take  = req_valid && req_ready;

   assign s1_ctl_in.calibrate  = req_calibrate;
   assign s1_ctl_in.in_range   = beam_ok && (req_range_mm <= max_range_ff);
   assign s1_ctl_in.beam_index = req_beam_index;

   lpc_trig_ram #(
      .DEPTH (BEAM_COUNT),
      .AW    (AW)
   ) u_trig_ram (
      .clock   (clock),
      .wr_en   (req_take && (req_operation == OP_LOAD) && beam_ok),
      .wr_addr (beam_addr),
      .wr_data ({req_cos_value, req_sin_value}),
      .rd_en   (en1),
      .rd_addr (beam_addr),
      .rd_data (trig_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en1) begin
         s1_valid_ff <= req_valid && (req_operation == OP_SAMPLE);
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_ctl_ff   <= s1_ctl_in;
         s1_range_ff <= req_range_mm;
      end
   end

   // stage 2
   sample_ctl_type s2_ctl;
   logic [QW-1:0]  s2_mag_x, s2_mag_y;
   logic           s2_neg_x, s2_neg_y;

   lpc_scale #(
      .FRAC (TRIG_FRAC_BITS),
      .QW   (QW)
   ) u_scale (
      .clock     (clock),
      .reset     (reset),
      .enable    (en2),
      .valid_in  (s1_valid_ff),
      .ctl_in    (s1_ctl_ff),
      .range_in  (s1_range_ff),
      .cos_in    ($signed(trig_rd[2*COEF_W-1:COEF_W])),
      .sin_in    ($signed(trig_rd[COEF_W-1:0])),
      .valid_out (s2_valid),
      .ctl_out   (s2_ctl),
      .mag_x     (s2_mag_x),
      .mag_y     (s2_mag_y),
      .neg_x     (s2_neg_x),
      .neg_y     (s2_neg_y)
   );

   // stage 3
   sample_ctl_type       s3_ctl;
   logic signed [XW-1:0] s3_x, s3_y;
   logic [2*QW-1:0]      s3_sq_x, s3_sq_y;

   lpc_place #(
      .QW (QW),
      .XW (XW)
   ) u_place (
      .clock     (clock),
      .reset     (reset),
      .enable    (en3),
      .valid_in  (s2_valid),
      .ctl_in    (s2_ctl),
      .mag_x     (s2_mag_x),
      .mag_y     (s2_mag_y),
      .neg_x     (s2_neg_x),
      .neg_y     (s2_neg_y),
      .pos_x     (pos_x_ff),
      .pos_y     (pos_y_ff),
      .valid_out (s3_valid),
      .ctl_out   (s3_ctl),
      .point_x   (s3_x),
      .point_y   (s3_y),
      .sq_x      (s3_sq_x),
      .sq_y      (s3_sq_y)
   );

   // stage 4 / response register
   lpc_filter #(
      .QW (QW),
      .XW (XW)
   ) u_filter (
      .clock        (clock),
      .reset        (reset),
      .enable       (en4),
      .valid_in     (s3_valid),
      .ctl_in       (s3_ctl),
      .point_x      (s3_x),
      .point_y      (s3_y),
      .sq_x         (s3_sq_x),
      .sq_y         (s3_sq_y),
      .edge_margin  (margin_ff),
      .field_size_x (field_x_ff),
      .field_size_y (field_y_ff),
      .ring_min_sq  (ring_min_ff),
      .ring_max_sq  (ring_max_ff),
      .valid_out    (rsp_valid),
      .out_x        (rsp_point_x),
      .out_y        (rsp_point_y),
      .out_ok       (rsp_point_valid),
      .out_index    (rsp_point_index)
   );

`ifndef SYNTHESIS
   // a load never enters the sample pipeline
   a_load_no_sample: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_operation == OP_LOAD)) |=> !s1_valid_ff)
      else $error("table load entered the sample pipeline");

   // the table read data must hold while stage 1 is stalled
   a_rd_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !en2) |=> (s1_valid_ff && $stable(trig_rd)))
      else $error("table read data changed during a stall");

   // back pressure only when every stage is occupied
   a_full_when_stalled: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (s1_valid_ff && s2_valid && s3_valid && rsp_valid))
      else $error("request stalled with an empty pipeline slot");

   // a rejected point carries zero coordinates
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_point_valid) |-> ((rsp_point_x == '0) && (rsp_point_y == '0)))
      else $error("rejected point with nonzero coordinates");
`endif

endmodule

// File: design/lpc_trig_ram.sv
// Per-beam cosine/sine table: one write port, one registered read port.
module lpc_trig_ram import lpc_pkg::*; #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [AW-1:0]         wr_addr,
   input  logic [2*COEF_W-1:0]   wr_data,
   input  logic                  rd_en,
   input  logic [AW-1:0]         rd_addr,
   output logic [2*COEF_W-1:0]   rd_data
);

   logic [2*COEF_W-1:0] mem_ff [DEPTH];
   logic [2*COEF_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // hold the read data while the stage behind it is stalled
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/lpc_scale.sv
// Stage 2: coefficient magnitude times range, scaled down by the fraction bits.
module lpc_scale import lpc_pkg::*; #(
   parameter int FRAC = 15,
   parameter int QW   = 32 - FRAC
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       enable,
   input  logic                       valid_in,
   input  sample_ctl_type             ctl_in,
   input  logic [RANGE_W-1:0]         range_in,
   input  logic signed [COEF_W-1:0]   cos_in,
   input  logic signed [COEF_W-1:0]   sin_in,
   output logic                       valid_out,
   output sample_ctl_type             ctl_out,
   output logic [QW-1:0]              mag_x,
   output logic [QW-1:0]              mag_y,
   output logic                       neg_x,
   output logic                       neg_y
);

   logic [COEF_W-1:0]   abs_cos, abs_sin;
   logic [2*COEF_W-1:0] prod_x, prod_y;

   logic           valid_ff;
   sample_ctl_type ctl_ff;
   logic [QW-1:0]  mag_x_ff, mag_y_ff;
   logic           neg_x_ff, neg_y_ff;

   // the most negative coefficient maps to 2^15, which fits unsigned
   assign abs_cos = cos_in[COEF_W-1] ? COEF_W'(-cos_in) : COEF_W'(cos_in);
   assign abs_sin = sin_in[COEF_W-1] ? COEF_W'(-sin_in) : COEF_W'(sin_in);
   assign prod_x  = (2*COEF_W)'(abs_cos) * (2*COEF_W)'(range_in);
   assign prod_y  = (2*COEF_W)'(abs_sin) * (2*COEF_W)'(range_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         ctl_ff   <= ctl_in;
         mag_x_ff <= prod_x[2*COEF_W-1:FRAC];
         mag_y_ff <= prod_y[2*COEF_W-1:FRAC];
         neg_x_ff <= cos_in[COEF_W-1];
         neg_y_ff <= sin_in[COEF_W-1];
      end
   end

   assign valid_out = valid_ff;
   assign ctl_out   = ctl_ff;
   assign mag_x     = mag_x_ff;
   assign mag_y     = mag_y_ff;
   assign neg_x     = neg_x_ff;
   assign neg_y     = neg_y_ff;

endmodule

// File: design/lpc_place.sv
// Stage 3: signed offsets plus sensor position, and squared offsets for the ring.
module lpc_place import lpc_pkg::*; #(
   parameter int QW = 17,
   parameter int XW = QW + 2
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      enable,
   input  logic                      valid_in,
   input  sample_ctl_type            ctl_in,
   input  logic [QW-1:0]             mag_x,
   input  logic [QW-1:0]             mag_y,
   input  logic                      neg_x,
   input  logic                      neg_y,
   input  logic signed [POS_W-1:0]   pos_x,
   input  logic signed [POS_W-1:0]   pos_y,
   output logic                      valid_out,
   output sample_ctl_type            ctl_out,
   output logic signed [XW-1:0]      point_x,
   output logic signed [XW-1:0]      point_y,
   output logic [2*QW-1:0]           sq_x,
   output logic [2*QW-1:0]           sq_y
);

   logic signed [QW:0]    dx, dy;
   logic signed [XW-1:0]  x_in, y_in;
   logic [2*QW-1:0]       sq_x_in, sq_y_in;

   logic                  valid_ff;
   sample_ctl_type        ctl_ff;
   logic signed [XW-1:0]  x_ff, y_ff;
   logic [2*QW-1:0]       sq_x_ff, sq_y_ff;

   assign dx      = neg_x ? -$signed({1'b0, mag_x}) : $signed({1'b0, mag_x});
   assign dy      = neg_y ? -$signed({1'b0, mag_y}) : $signed({1'b0, mag_y});
   assign x_in    = XW'(dx) + XW'(pos_x);
   assign y_in    = XW'(dy) + XW'(pos_y);
   assign sq_x_in = (2*QW)'(mag_x) * (2*QW)'(mag_x);
   assign sq_y_in = (2*QW)'(mag_y) * (2*QW)'(mag_y);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         ctl_ff  <= ctl_in;
         x_ff    <= x_in;
         y_ff    <= y_in;
         sq_x_ff <= sq_x_in;
         sq_y_ff <= sq_y_in;
      end
   end

   assign valid_out = valid_ff;
   assign ctl_out   = ctl_ff;
   assign point_x   = x_ff;
   assign point_y   = y_ff;
   assign sq_x      = sq_x_ff;
   assign sq_y      = sq_y_ff;

endmodule

// File: design/lpc_filter.sv
// Stage 4: field or ring checks, saturation and the response register.
module lpc_filter import lpc_pkg::*; #(
   parameter int QW = 17,
   parameter int XW = QW + 2
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      enable,
   input  logic                      valid_in,
   input  sample_ctl_type            ctl_in,
   input  logic signed [XW-1:0]      point_x,
   input  logic signed [XW-1:0]      point_y,
   input  logic [2*QW-1:0]           sq_x,
   input  logic [2*QW-1:0]           sq_y,
   input  logic [MARGIN_W-1:0]       edge_margin,
   input  logic [FIELD_W-1:0]        field_size_x,
   input  logic [FIELD_W-1:0]        field_size_y,
   input  logic [RING_W-1:0]         ring_min_sq,
   input  logic [RING_W-1:0]         ring_max_sq,
   output logic                      valid_out,
   output logic signed [POINT_W-1:0] out_x,
   output logic signed [POINT_W-1:0] out_y,
   output logic                      out_ok,
   output logic [BEAM_W-1:0]         out_index
);

   localparam int CW = XW + 1;
   localparam int DW = 2 * QW + 1;

   function automatic logic signed [POINT_W-1:0] saturate(input logic signed [XW-1:0] v);
      logic signed [XW-1:0] hi, lo;
      hi = $signed(XW'(POINT_MAX));
      lo = $signed(XW'(POINT_MIN));
      if (v > hi) begin
         return $signed(POINT_W'(POINT_MAX));
      end else if (v < lo) begin
         return $signed(POINT_W'(POINT_MIN));
      end
      return POINT_W'(v);
   endfunction

   logic signed [CW-1:0] margin_s, hi_x, hi_y, x_c, y_c;
   logic [DW-1:0]        dist_sq;
   logic                 field_ok, ring_ok, ok_in;

   logic                      valid_ff;
   logic signed [POINT_W-1:0] x_ff, y_ff;
   logic                      ok_ff;
   logic [BEAM_W-1:0]         index_ff;

   assign margin_s = CW'($signed({1'b0, edge_margin}));
   assign hi_x     = CW'($signed({1'b0, field_size_x})) - margin_s;
   assign hi_y     = CW'($signed({1'b0, field_size_y})) - margin_s;
   assign x_c      = CW'(point_x);
   assign y_c      = CW'(point_y);
   // borders are inclusive; an inset wider than the field rejects everything
   assign field_ok = (x_c >= margin_s) && (x_c <= hi_x) &&
                     (y_c >= margin_s) && (y_c <= hi_y);

   assign dist_sq  = DW'(sq_x) + DW'(sq_y);
   assign ring_ok  = (dist_sq >= DW'(ring_min_sq)) && (dist_sq <= DW'(ring_max_sq));

   assign ok_in    = ctl_in.in_range && (ctl_in.calibrate ? ring_ok : field_ok);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff     <= ok_in ? saturate(point_x) : '0;
         y_ff     <= ok_in ? saturate(point_y) : '0;
         ok_ff    <= ok_in;
         index_ff <= ctl_in.beam_index;
      end
   end

   assign valid_out = valid_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_ok    = ok_ff;
   assign out_index = index_ff;

endmodule
